FILE: src/itx_pkg.sv
// Shared types and constants for the 4x4 inverse integer transform.
// Depends on nothing; used by every module of the block.
package itx_pkg;

    localparam int unsigned ROUND_BIAS = 32;
    localparam int unsigned ROUND_SHIFT = 6;
    localparam logic [1:0] LAST_ROW_IDX = 2'd3;
    localparam logic [2:0] ROWS_PER_BLOCK = 3'd4;

    typedef logic [3:0][15:0] t_vec4;
    typedef logic [3:0][3:0][15:0] t_blk;

    typedef struct packed {
        logic signed [15:0] coef_0;
        logic signed [15:0] coef_1;
        logic signed [15:0] coef_2;
        logic signed [15:0] coef_3;
    } t_coef_row;

    typedef struct packed {
        logic signed [15:0] pel_0;
        logic signed [15:0] pel_1;
        logic signed [15:0] pel_2;
        logic signed [15:0] pel_3;
        logic        [1:0]  row_number;
        logic               last_row;
    } t_pel_row;

endpackage

FILE: src/inverse_transform_4x4.sv
// Top level of the 4x4 inverse integer transform: row buffer, column pass,
// intermediate bank, row pass and output register. Depends on itx_pkg,
// itx_col_pass and itx_row_pass.
//
// Coefficient rows enter one per cycle while o_in_stall is low, top row first.
// The first three rows are buffered; the transfer of the fourth runs the column
// pass into a bank of intermediates in the same cycle. The bank then drains one
// result row per cycle while the output is not stalled, through the row pass into
// the output register, rows 0 to 3, with last_row set on row 3. The first result
// row goes to the output register once the fourth row is in; intake and drain
// overlap, so with no downstream stall the block sustains one row per cycle. The
// fourth row of the next block is held off only while the bank still has more
// than one row to drain, or its one remaining row is held by a downstream stall.
module inverse_transform_4x4 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  itx_pkg::t_coef_row i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output itx_pkg::t_pel_row  o_out_data,
    input  logic               i_out_stall
);
    import itx_pkg::*;

    t_vec4      r_coef [3];
    t_blk       r_mid;
    logic [1:0] r_rows, n_rows;
    logic [2:0] r_pend, n_pend;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_pel_row   r_out;

    t_vec4 in_row;
    t_blk  col_mid;
    t_vec4 row_pel;
    logic  in_xfer, adv, mid_free, blk_done;

    assign in_row   = {i_in_data.coef_3, i_in_data.coef_2, i_in_data.coef_1, i_in_data.coef_0};
    assign adv      = (r_pend != 3'd0) && (!r_out_valid || !i_out_stall);
    assign mid_free = (r_pend == 3'd0) || ((r_pend == 3'd1) && adv);
    assign o_in_stall = (r_rows == LAST_ROW_IDX) && !mid_free;
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign blk_done = in_xfer && (r_rows == LAST_ROW_IDX);

    itx_col_pass u_col (
        .i_row0 (r_coef[0]),
        .i_row1 (r_coef[1]),
        .i_row2 (r_coef[2]),
        .i_row3 (in_row),
        .o_mid  (col_mid)
    );

    itx_row_pass u_row (
        .i_mid (r_mid[r_idx]),
        .o_pel (row_pel)
    );

    always_comb begin
        n_rows      = in_xfer ? r_rows + 2'd1 : r_rows;
        n_pend      = adv ? r_pend - 3'd1 : r_pend;
        n_idx       = adv ? r_idx + 2'd1 : r_idx;
        n_out_valid = adv ? 1'b1 : (r_out_valid && i_out_stall);
        if (blk_done) begin
            n_pend = ROWS_PER_BLOCK;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 2'd0;
            r_pend      <= 3'd0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_rows      <= n_rows;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (in_xfer && (r_rows == 2'(k))) begin
                r_coef[k] <= in_row;
            end
        end
        if (blk_done) begin
            r_mid <= col_mid;
        end
        if (adv) begin
            r_out.pel_0      <= signed'(row_pel[0]);
            r_out.pel_1      <= signed'(row_pel[1]);
            r_out.pel_2      <= signed'(row_pel[2]);
            r_out.pel_3      <= signed'(row_pel[3]);
            r_out.row_number <= r_idx;
            r_out.last_row   <= (r_idx == LAST_ROW_IDX);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |-> mid_free)
        else $error("intermediate bank overwritten before drained");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_row == (o_out_data.row_number == LAST_ROW_IDX)))
        else $error("last_row flag does not match row number");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 3'd0) |-> (r_idx == 2'(ROWS_PER_BLOCK - r_pend)))
        else $error("drain index out of step with pending count");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 3'd0 && !adv && !blk_done) |=> (r_pend == $past(r_pend)))
        else $error("pending count moved without an output transfer");

endmodule

FILE: src/itx_col_pass.sv
// Column butterfly of the 4x4 inverse transform, 16-bit wrapping arithmetic.
// Depends on itx_pkg.
module itx_col_pass (
    input  itx_pkg::t_vec4 i_row0,
    input  itx_pkg::t_vec4 i_row1,
    input  itx_pkg::t_vec4 i_row2,
    input  itx_pkg::t_vec4 i_row3,
    output itx_pkg::t_blk  o_mid
);
    import itx_pkg::*;

    always_comb begin
        logic signed [15:0] s0, s1, s2, s3, e0, e1, o0, o1;
        for (int c = 0; c < 4; c++) begin
            s0 = signed'(i_row0[c]);
            s1 = signed'(i_row1[c]);
            s2 = signed'(i_row2[c]);
            s3 = signed'(i_row3[c]);
            e0 = s0 + s2;
            e1 = s0 - s2;
            o0 = (s1 >>> 1) - s3;
            o1 = s1 + (s3 >>> 1);
            o_mid[0][c] = e0 + o1;
            o_mid[1][c] = e1 + o0;
            o_mid[2][c] = e1 - o0;
            o_mid[3][c] = e0 - o1;
        end
    end

endmodule

FILE: src/itx_row_pass.sv
// Row butterfly of the 4x4 inverse transform with rounding and final scaling.
// Depends on itx_pkg.
module itx_row_pass (
    input  itx_pkg::t_vec4 i_mid,
    output itx_pkg::t_vec4 o_pel
);
    import itx_pkg::*;

    always_comb begin
        logic signed [18:0] t0, t1, t2, t3;
        logic signed [18:0] e0, e1, o0, o1;
        logic signed [18:0] bias;
        logic signed [18:0] y0, y1, y2, y3;
        t0 = 19'(signed'(i_mid[0]));
        t1 = 19'(signed'(i_mid[1]));
        t2 = 19'(signed'(i_mid[2]));
        t3 = 19'(signed'(i_mid[3]));
        bias = 19'(ROUND_BIAS);
        e0 = t0 + t2;
        e1 = t0 - t2;
        o0 = (t1 >>> 1) - t3;
        o1 = t1 + (t3 >>> 1);
        y0 = (e0 + o1 + bias) >>> ROUND_SHIFT;
        y1 = (e1 + o0 + bias) >>> ROUND_SHIFT;
        y2 = (e1 - o0 + bias) >>> ROUND_SHIFT;
        y3 = (e0 - o1 + bias) >>> ROUND_SHIFT;
        o_pel[0] = y0[15:0];
        o_pel[1] = y1[15:0];
        o_pel[2] = y2[15:0];
        o_pel[3] = y3[15:0];
    end

endmodule
